/* hw/rtl/energy_zcr_word_detector_top_defines.svh */
// Assertion macros for the energy / zero crossing word detector.
// All checks are clocked on aclk and held off while aresetn is low.
`ifndef ENERGY_ZCR_WORD_DETECTOR_TOP_DEFINES_SVH
`define ENERGY_ZCR_WORD_DETECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define EZWD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> cons) \
        else $error("ezwd: same-cycle check failed");
// Implication on the following cycle.
`define EZWD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> cons) \
        else $error("ezwd: next-cycle check failed");
`else
`define EZWD_ASSERT_NOW(label, ante, cons)
`define EZWD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/ezwd_pkg.sv */
package ezwd_pkg;

    localparam int unsigned SampleW   = 16;
    localparam int unsigned PosW      = 16;
    localparam int unsigned FrameposW = 10;
    localparam int unsigned FlenW     = 11;
    localparam int unsigned EnergyW   = 41;
    localparam int unsigned SquareW   = 31;
    localparam int unsigned RateW     = 10;
    localparam int unsigned LenW      = PosW + 1;
    localparam int unsigned ScaledW   = 26;
    localparam int unsigned ProdW     = RateW + LenW;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = EnergyW;

    localparam int unsigned MaxFrame      = 1024;
    localparam int unsigned PermilleScale = 1000;

    localparam logic [EnergyW-1:0] ThresholdReset = EnergyW'(10000);
    localparam logic [RateW-1:0]   RateReset      = RateW'(70);
    localparam logic [FlenW-1:0]   FrameLenReset  = FlenW'(400);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LEVEL_LIMIT      = 2'd0,
        CFG_RATE_PERMILLE    = 2'd1,
        CFG_FRAME_LENGTH     = 2'd2
    } cfg_reg_t;

    // sample plus its square, handed from the front pipe to the tracker
    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic                      last;
        logic [SquareW-1:0]        square;
    } sq_item_t;

    // per-recording summary handed from the tracker to the decision stage
    typedef struct packed {
        logic               speech_found;
        logic [PosW-1:0]    span_start;
        logic [PosW-1:0]    span_end;
        logic [PosW-1:0]    crossing_count;
        logic [LenW-1:0]    span_len;
    } span_t;

    // 0 acts as 1, anything above MaxFrame acts as MaxFrame
    function automatic logic [FlenW-1:0] clamp_frame_length(input logic [FlenW-1:0] v);
        logic [FlenW-1:0] r;
        if (v == '0) begin
            r = FlenW'(1);
        end else if (v > FlenW'(MaxFrame)) begin
            r = FlenW'(MaxFrame);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ezwd_front.sv */
module ezwd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ezwd_pkg::SampleW-1:0] s_sample,
    input  logic                                s_last,
    output logic                                item_valid,
    output ezwd_pkg::sq_item_t                  item,
    input  logic                                item_ready
);

    logic                                p1_valid_reg, p1_valid_next;
    logic signed [ezwd_pkg::SampleW-1:0] p1_sample_reg;
    logic                                p1_last_reg;
    logic                                p2_valid_reg, p2_valid_next;
    ezwd_pkg::sq_item_t                  p2_item_reg, p2_item_next;

    logic                                s_accept;
    logic                                p1_move;
    logic                                p2_free;
    logic signed [2*ezwd_pkg::SampleW-1:0] square_full;

    assign p2_free  = !p2_valid_reg || item_ready;
    assign p1_move  = p1_valid_reg && p2_free;
    assign s_ready  = !p1_valid_reg || p1_move;
    assign s_accept = s_valid && s_ready;

    assign square_full = p1_sample_reg * p1_sample_reg;

    always_comb begin
        p1_valid_next       = s_accept || (p1_valid_reg && !p1_move);
        p2_valid_next       = p1_move || (p2_valid_reg && !item_ready);
        p2_item_next.sample = p1_sample_reg;
        p2_item_next.last   = p1_last_reg;
        // square of a 16-bit value is at most 2^30
        p2_item_next.square = square_full[ezwd_pkg::SquareW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_sample_reg <= s_sample;
            p1_last_reg   <= s_last;
        end
        if (p1_move) begin
            p2_item_reg <= p2_item_next;
        end
    end

    assign item_valid = p2_valid_reg;
    assign item       = p2_item_reg;

endmodule

/* hw/rtl/ezwd_track.sv */
module ezwd_track (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ezwd_pkg::EnergyW-1:0]      level_limit,
    input  logic [ezwd_pkg::FlenW-1:0]        frame_length,
    input  logic                              item_valid,
    input  ezwd_pkg::sq_item_t                item,
    output logic                              item_ready,
    output logic                              res_valid,
    output ezwd_pkg::span_t                   res,
    input  logic                              res_ready
);

    logic [ezwd_pkg::EnergyW-1:0]        energy_sum_reg,  energy_sum_next;
    logic [ezwd_pkg::FrameposW-1:0]      frame_pos_reg,   frame_pos_next;
    logic [ezwd_pkg::PosW-1:0]           sample_pos_reg,  sample_pos_next;
    logic signed [ezwd_pkg::SampleW-1:0] prev_sample_reg, prev_sample_next;
    logic                                started_reg,     started_next;
    logic                                ended_reg,       ended_next;
    logic [ezwd_pkg::PosW-1:0]           start_pos_reg,   start_pos_next;
    logic [ezwd_pkg::PosW-1:0]           end_pos_reg,     end_pos_next;
    logic [ezwd_pkg::PosW-1:0]           total_cross_reg, total_cross_next;
    logic [ezwd_pkg::PosW-1:0]           span_cross_reg,  span_cross_next;
    logic [ezwd_pkg::FrameposW-1:0]      frame_cross_reg, frame_cross_next;

    logic                                accept;
    logic                                is_last;
    logic [ezwd_pkg::FlenW-1:0]          flen;
    logic                                crossing;
    logic [ezwd_pkg::PosW-1:0]           total_inc;
    logic [ezwd_pkg::PosW-1:0]           span_inc;
    logic [ezwd_pkg::FrameposW-1:0]      frame_inc;
    logic [ezwd_pkg::EnergyW-1:0]        sum_inc;
    logic                                frame_done;
    logic                                judge;
    logic [ezwd_pkg::PosW-1:0]           frame_start;
    logic                                start_hit;
    logic                                end_hit;
    logic [ezwd_pkg::PosW-1:0]           span_lo;
    logic [ezwd_pkg::PosW-1:0]           span_hi;

    // the top index of the position counter closes the recording on its own
    assign is_last    = item.last || (sample_pos_reg == '1);
    assign item_ready = !is_last || res_ready;
    assign res_valid  = item_valid && is_last;
    assign accept     = item_valid && item_ready;

    assign flen = ezwd_pkg::clamp_frame_length(frame_length);

    assign crossing = (sample_pos_reg != '0) &&
                      (((prev_sample_reg > 0) && (item.sample < 0)) ||
                       ((prev_sample_reg < 0) && (item.sample > 0)));

    assign total_inc = total_cross_reg + ezwd_pkg::PosW'(crossing);
    assign span_inc  = span_cross_reg +
                       ezwd_pkg::PosW'(crossing && started_reg && !ended_reg);
    assign frame_inc = frame_cross_reg +
                       ezwd_pkg::FrameposW'(crossing && (frame_pos_reg != '0));
    assign sum_inc   = energy_sum_reg + ezwd_pkg::EnergyW'(item.square);

    assign frame_done  = (ezwd_pkg::FlenW'(frame_pos_reg) + ezwd_pkg::FlenW'(1)) >= flen;
    assign judge       = frame_done && !is_last && !ended_reg;
    assign frame_start = sample_pos_reg - ezwd_pkg::PosW'(frame_pos_reg);
    assign start_hit   = judge && !started_reg && (sum_inc > level_limit);
    assign end_hit     = judge && started_reg && (sum_inc < level_limit);

    // summary as seen on the closing sample
    assign span_lo = started_reg ? start_pos_reg : '0;
    assign span_hi = ended_reg ? end_pos_reg : sample_pos_reg;

    always_comb begin
        res.speech_found   = started_reg;
        res.span_start     = span_lo;
        res.span_end       = span_hi;
        res.crossing_count = started_reg ? span_inc : total_inc;
        res.span_len       = ezwd_pkg::LenW'(span_hi) - ezwd_pkg::LenW'(span_lo) +
                             ezwd_pkg::LenW'(1);
    end

    always_comb begin
        energy_sum_next  = energy_sum_reg;
        frame_pos_next   = frame_pos_reg;
        sample_pos_next  = sample_pos_reg;
        prev_sample_next = prev_sample_reg;
        started_next     = started_reg;
        ended_next       = ended_reg;
        start_pos_next   = start_pos_reg;
        end_pos_next     = end_pos_reg;
        total_cross_next = total_cross_reg;
        span_cross_next  = span_cross_reg;
        frame_cross_next = frame_cross_reg;
        if (accept) begin
            if (is_last) begin
                energy_sum_next  = '0;
                frame_pos_next   = '0;
                sample_pos_next  = '0;
                prev_sample_next = '0;
                started_next     = 1'b0;
                ended_next       = 1'b0;
                start_pos_next   = '0;
                end_pos_next     = '0;
                total_cross_next = '0;
                span_cross_next  = '0;
                frame_cross_next = '0;
            end else begin
                total_cross_next = total_inc;
                if (start_hit) begin
                    started_next    = 1'b1;
                    start_pos_next  = frame_start;
                    span_cross_next = ezwd_pkg::PosW'(frame_inc);
                end else if (end_hit) begin
                    // crossings inside the end frame leave the span again
                    ended_next      = 1'b1;
                    end_pos_next    = frame_start;
                    span_cross_next = span_inc - ezwd_pkg::PosW'(frame_inc);
                end else begin
                    span_cross_next = span_inc;
                end
                if (frame_done) begin
                    energy_sum_next  = '0;
                    frame_pos_next   = '0;
                    frame_cross_next = '0;
                end else begin
                    energy_sum_next  = sum_inc;
                    frame_pos_next   = frame_pos_reg + ezwd_pkg::FrameposW'(1);
                    frame_cross_next = frame_inc;
                end
                prev_sample_next = item.sample;
                sample_pos_next  = sample_pos_reg + ezwd_pkg::PosW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_sum_reg  <= '0;
            frame_pos_reg   <= '0;
            sample_pos_reg  <= '0;
            prev_sample_reg <= '0;
            started_reg     <= 1'b0;
            ended_reg       <= 1'b0;
            start_pos_reg   <= '0;
            end_pos_reg     <= '0;
            total_cross_reg <= '0;
            span_cross_reg  <= '0;
            frame_cross_reg <= '0;
        end else begin
            energy_sum_reg  <= energy_sum_next;
            frame_pos_reg   <= frame_pos_next;
            sample_pos_reg  <= sample_pos_next;
            prev_sample_reg <= prev_sample_next;
            started_reg     <= started_next;
            ended_reg       <= ended_next;
            start_pos_reg   <= start_pos_next;
            end_pos_reg     <= end_pos_next;
            total_cross_reg <= total_cross_next;
            span_cross_reg  <= span_cross_next;
            frame_cross_reg <= frame_cross_next;
        end
    end

endmodule

/* hw/rtl/ezwd_decide.sv */
module ezwd_decide (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ezwd_pkg::RateW-1:0]    crossing_rate_permille,
    input  logic                          res_valid,
    input  ezwd_pkg::span_t               res,
    output logic                          res_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_word_is_yes,
    output logic                          m_speech_found,
    output logic [ezwd_pkg::PosW-1:0]     m_span_start,
    output logic [ezwd_pkg::PosW-1:0]     m_span_end,
    output logic [ezwd_pkg::PosW-1:0]     m_crossing_count
);

    logic                            c_valid_reg, c_valid_next;
    ezwd_pkg::span_t                 c_span_reg;
    logic                            m_valid_reg, m_valid_next;
    logic                            yes_reg;
    ezwd_pkg::span_t                 m_span_reg;

    logic                            out_free;
    logic                            c_move;
    logic                            c_load;
    logic [ezwd_pkg::ScaledW-1:0]    scaled_count;
    logic [ezwd_pkg::ProdW-1:0]      rate_times_len;
    logic                            yes;

    assign out_free  = !m_valid_reg || m_ready;
    assign c_move    = c_valid_reg && out_free;
    assign res_ready = !c_valid_reg || out_free;
    assign c_load    = res_valid && res_ready;

    // count*1000 against rate*length
    assign scaled_count   = ezwd_pkg::ScaledW'(c_span_reg.crossing_count) *
                            ezwd_pkg::ScaledW'(ezwd_pkg::PermilleScale);
    assign rate_times_len = ezwd_pkg::ProdW'(crossing_rate_permille) *
                            ezwd_pkg::ProdW'(c_span_reg.span_len);
    assign yes            = ezwd_pkg::ProdW'(scaled_count) > rate_times_len;

    assign c_valid_next = c_load || (c_valid_reg && !c_move);
    assign m_valid_next = c_move || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            c_span_reg <= res;
        end
        if (c_move) begin
            m_span_reg <= c_span_reg;
            yes_reg    <= yes;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_word_is_yes    = yes_reg;
    assign m_speech_found   = m_span_reg.speech_found;
    assign m_span_start     = m_span_reg.span_start;
    assign m_span_end       = m_span_reg.span_end;
    assign m_crossing_count = m_span_reg.crossing_count;

endmodule

/* hw/rtl/energy_zcr_word_detector_top.sv */
// Energy / zero crossing rate endpoint detector, one recording at a time.
// Input request (s_valid/s_ready): one signed 16-bit sample; s_last marks the
// final sample of a recording. Output request (m_valid/m_ready): one summary
// per recording (yes decision, speech flag, span start/end, crossing count).
// Config: cfg_we writes cfg_data into register cfg_index (0 energy
// threshold, 1 crossing rate in permille, 2 frame length). Write only while
// no recording is in flight.
// Throughput: one sample per cycle while the front pipe is not stalled. The
// per-sample state update (square-accumulate, frame judge, crossing count) is
// combinational into the tracker registers. Path: the final sample passes the
// input reg, square reg, decision reg and output reg before m_valid rises.
// Stall: a blocked output only backs up when a closing sample reaches the
// tracker while the decision and output stages are both full; ordinary samples
// keep flowing. s_ready drops only when the front pipe is full and stuck.
// Reset: aresetn (sync, active low) empties the pipe, clears the recording
// state and loads threshold 10000, rate 70 permille, frame length 400.
// A recording is closed at index 65535 even without s_last.
`include "energy_zcr_word_detector_top_defines.svh"

module energy_zcr_word_detector_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ezwd_pkg::SampleW-1:0]  s_sample,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_word_is_yes,
    output logic                                 m_speech_found,
    output logic [ezwd_pkg::PosW-1:0]            m_span_start,
    output logic [ezwd_pkg::PosW-1:0]            m_span_end,
    output logic [ezwd_pkg::PosW-1:0]            m_crossing_count,
    input  logic                                 cfg_we,
    input  logic [ezwd_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [ezwd_pkg::CfgDataW-1:0]        cfg_data
);

    // configuration registers
    logic [ezwd_pkg::EnergyW-1:0] threshold_reg, threshold_next;
    logic [ezwd_pkg::RateW-1:0]   rate_reg,      rate_next;
    logic [ezwd_pkg::FlenW-1:0]   flen_reg,      flen_next;

    // front pipe -> tracker
    logic                         f_item_valid;
    ezwd_pkg::sq_item_t           f_item;
    logic                         f_item_ready;

    // tracker -> decision
    logic                         res_valid;
    ezwd_pkg::span_t              res;
    logic                         res_ready;

    always_comb begin
        threshold_next = threshold_reg;
        rate_next      = rate_reg;
        flen_next      = flen_reg;
        if (cfg_we) begin
            case (ezwd_pkg::cfg_reg_t'(cfg_index))
                ezwd_pkg::CFG_LEVEL_LIMIT: begin
                    threshold_next = cfg_data;
                end
                ezwd_pkg::CFG_RATE_PERMILLE: begin
                    rate_next = cfg_data[ezwd_pkg::RateW-1:0];
                end
                ezwd_pkg::CFG_FRAME_LENGTH: begin
                    flen_next = cfg_data[ezwd_pkg::FlenW-1:0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= ezwd_pkg::ThresholdReset;
            rate_reg      <= ezwd_pkg::RateReset;
            flen_reg      <= ezwd_pkg::FrameLenReset;
        end else begin
            threshold_reg <= threshold_next;
            rate_reg      <= rate_next;
            flen_reg      <= flen_next;
        end
    end

    // input register and squarer
    ezwd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .s_last     (s_last),
        .item_valid (f_item_valid),
        .item       (f_item),
        .item_ready (f_item_ready)
    );

    // per-recording state: frame energy, endpoints, crossing counts
    ezwd_track u_track (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .level_limit      (threshold_reg),
        .frame_length     (flen_reg),
        .item_valid       (f_item_valid),
        .item             (f_item),
        .item_ready       (f_item_ready),
        .res_valid        (res_valid),
        .res              (res),
        .res_ready        (res_ready)
    );

    // rate compare and output register
    ezwd_decide u_decide (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .crossing_rate_permille (rate_reg),
        .res_valid              (res_valid),
        .res                    (res),
        .res_ready              (res_ready),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_word_is_yes          (m_word_is_yes),
        .m_speech_found         (m_speech_found),
        .m_span_start           (m_span_start),
        .m_span_end             (m_span_end),
        .m_crossing_count       (m_crossing_count)
    );

    // input backpressure only comes from a stuck item at the tracker
    `EZWD_ASSERT_NOW(a_stall_has_cause, !s_ready, (f_item_valid && !f_item_ready))
    // a summary taken by the decision stage reaches the output via the output reg
    `EZWD_ASSERT_NOW(a_summary_reaches_out, (res_valid && res_ready), ##2 m_valid)
    // the judged span is never empty or reversed
    `EZWD_ASSERT_NOW(a_span_ordered, res_valid, (res.span_end >= res.span_start && res.span_len != '0))

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ezwd_pkg::*;

    // ------------------------------------------------------------------
    // DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [SampleW-1:0]  s_sample  = '0;
    logic                       s_last    = 1'b0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic                       m_word_is_yes;
    logic                       m_speech_found;
    logic [PosW-1:0]            m_span_start;
    logic [PosW-1:0]            m_span_end;
    logic [PosW-1:0]            m_crossing_count;
    logic                       cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]         cfg_index = CFG_LEVEL_LIMIT;
    logic [CfgDataW-1:0]        cfg_data  = '0;

    energy_zcr_word_detector_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_word_is_yes    (m_word_is_yes),
        .m_speech_found   (m_speech_found),
        .m_span_start     (m_span_start),
        .m_span_end       (m_span_end),
        .m_crossing_count (m_crossing_count),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #1 aclk = ~aclk;

    // One summary per recording, in the same field order as the output request.
    typedef struct packed {
        logic            word_is_yes;
        logic            speech_found;
        logic [PosW-1:0] span_start;
        logic [PosW-1:0] span_end;
        logic [PosW-1:0] crossing_count;
    } word_summary_t;

    word_summary_t pending_summaries[$];

    int unsigned mismatches        = 0;
    int unsigned recordings_sent   = 0;
    int unsigned samples_sent      = 0;
    int unsigned summaries_checked = 0;
    int unsigned speech_summaries  = 0;

    // idle / stall rates in percent, changed per phase
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;

    // ------------------------------------------------------------------
    // Endpoint tracker: register copies plus per-recording state.
    // ------------------------------------------------------------------
    logic [EnergyW-1:0]        thr_q;
    logic [RateW-1:0]          rate_q;
    logic [FlenW-1:0]          flen_q;

    longint unsigned           energy_acc;
    int unsigned               frame_pos;
    int unsigned               rec_pos;
    logic signed [SampleW-1:0] prev_smp;
    bit                        started;
    bit                        ended;
    int unsigned               start_at;
    int unsigned               end_at;
    int unsigned               total_x;
    int unsigned               span_x;
    int unsigned               frame_x;

    task automatic clear_tracker();
        energy_acc = 0;
        frame_pos  = 0;
        rec_pos    = 0;
        prev_smp   = '0;
        started    = 1'b0;
        ended      = 1'b0;
        start_at   = 0;
        end_at     = 0;
        total_x    = 0;
        span_x     = 0;
        frame_x    = 0;
    endtask

    // Advance the tracker by one accepted sample; queue a summary when the
    // recording closes (s_last, or the index cap at 65535).
    task automatic track_sample(input logic signed [SampleW-1:0] smp, input logic is_last);
        int unsigned     flen;
        bit              closing;
        int unsigned     st;
        int unsigned     en;
        int unsigned     cnt;
        longint unsigned span_len;
        word_summary_t   ws;
        flen = (flen_q == '0) ? 1 : ((flen_q > FlenW'(MaxFrame)) ? MaxFrame : int'(flen_q));
        closing = is_last || (rec_pos >= 65535);

        // strict sign change; zero on either side never counts
        if (rec_pos > 0 && ((prev_smp > 0 && smp < 0) || (prev_smp < 0 && smp > 0))) begin
            total_x++;
            if (started && !ended)
                span_x++;
            if (frame_pos > 0)
                frame_x++;
        end

        energy_acc += longint'(smp) * longint'(smp);

        if (frame_pos + 1 >= flen) begin
            // a frame closing on the final sample is not judged
            if (!closing && !ended) begin
                if (!started && energy_acc > thr_q) begin
                    started  = 1'b1;
                    start_at = rec_pos - frame_pos;
                    span_x   = frame_x;
                end else if (started && energy_acc < thr_q) begin
                    ended  = 1'b1;
                    end_at = rec_pos - frame_pos;
                    span_x -= frame_x;   // end frame's inner crossings drop out
                end
            end
            energy_acc = 0;
            frame_pos  = 0;
            frame_x    = 0;
        end else begin
            frame_pos++;
        end

        if (closing) begin
            st       = started ? start_at : 0;
            en       = ended ? end_at : rec_pos;
            cnt      = started ? span_x : total_x;
            span_len = longint'(en - st) + 1;
            ws.word_is_yes    = (longint'(cnt) * PermilleScale) > (longint'(rate_q) * span_len);
            ws.speech_found   = started;
            ws.span_start     = PosW'(st);
            ws.span_end       = PosW'(en);
            ws.crossing_count = PosW'(cnt);
            pending_summaries.push_back(ws);
            recordings_sent++;
            clear_tracker();
        end else begin
            prev_smp = smp;
            rec_pos++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Gap length: mostly none, otherwise short, now and then long.
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic logic signed [SampleW-1:0] level_sample(int unsigned lo, int unsigned hi);
        int mag;
        mag = int'($urandom_range(hi, lo));
        return $urandom_range(1) ? SampleW'(-mag) : SampleW'(mag);
    endfunction

    // Send one sample request. Valid stays high on return; the next call
    // (or settle) changes it at the following falling edge.
    task automatic send_sample(input logic signed [SampleW-1:0] smp, input logic is_last);
        int unsigned gap;
        gap = pick_gap(in_idle_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= is_last;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        track_sample(smp, is_last);
    endtask

    // Drop valid, wait for every summary, then let the pipe drain.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LEVEL_LIMIT:      thr_q  = val;
            CFG_RATE_PERMILLE:    rate_q = val[RateW-1:0];
            CFG_FRAME_LENGTH:     flen_q = val[FlenW-1:0];
            default: ;
        endcase
    endtask

    task automatic send_frames(int unsigned n_frames, int unsigned lo, int unsigned hi,
                               int unsigned flen);
        repeat (n_frames * flen) send_sample(level_sample(lo, hi), 1'b0);
    endtask

    // Quiet lead-in, loud frames, quiet frames, then a noisy tail.
    // With threshold = flen*amp^2, quiet frames sit below it and loud ones above.
    task automatic send_shaped_recording(int unsigned amp, int unsigned flen);
        int unsigned n_tail;
        send_frames($urandom_range(2, 0), 0, amp / 2, flen);
        send_frames($urandom_range(3, 1), 2 * amp, 32767, flen);
        send_frames($urandom_range(2, 0), 0, amp / 2, flen);
        n_tail = $urandom_range(2 * flen, 1);
        for (int unsigned i = 1; i <= n_tail; i++)
            send_sample(SampleW'($urandom()), i == n_tail);
    endtask

    task automatic send_noise_recording();
        int unsigned n;
        n = $urandom_range(40, 1);
        for (int unsigned i = 1; i <= n; i++)
            send_sample(SampleW'($urandom()), i == n);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: one loud 400-sample frame starts speech, a short tail closes.
    task automatic test_reset_settings();
        settle();
        in_idle_pct   = 10;
        out_stall_pct = 20;
        send_frames(1, 1000, 32767, 400);
        for (int i = 1; i <= 20; i++)
            send_sample(SampleW'($urandom()), i == 20);
    endtask

    // Short hand-built recordings for the corner cases.
    task automatic test_directed_cases();
        logic signed [SampleW-1:0] walk[14];
        settle();
        write_reg(CFG_LEVEL_LIMIT, 100);
        write_reg(CFG_RATE_PERMILLE, 250);
        write_reg(CFG_FRAME_LENGTH, 4);
        in_idle_pct   = 30;
        out_stall_pct = 30;
        // one-sample recordings at both sample extremes
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b1);
        // silent frame, loud frame (start), quiet frame with a zero (end), tail
        walk = '{0, 0, 0, 0, 100, -100, 100, -100, 1, -1, 0, 1, 5, -5};
        foreach (walk[i])
            send_sample(walk[i], i == 13);
        // loud frame that completes on the final sample: never judged
        send_sample(16'sd200, 1'b0);
        send_sample(-16'sd200, 1'b0);
        send_sample(16'sd200, 1'b0);
        send_sample(-16'sd200, 1'b1);
        settle();
        // frame length zero behaves as one
        write_reg(CFG_FRAME_LENGTH, 0);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd1000, 1'b1);
        settle();
        // frame length past the widest frame: no frame closes early
        write_reg(CFG_FRAME_LENGTH, {FlenW{1'b1}});
        send_sample(16'sd3000, 1'b0);
        send_sample(-16'sd3000, 1'b0);
        send_sample(16'sd3000, 1'b1);
    endtask

    // Phases of random settings, each with a handful of recordings.
    task automatic test_random_recordings();
        int unsigned          first_sample;
        int unsigned          f;
        int unsigned          amp;
        logic [FlenW-1:0]     flen_val;
        logic [CfgDataW-1:0]  thr_val;
        first_sample = samples_sent;
        while (samples_sent - first_sample < 850) begin
            settle();
            case ($urandom_range(9))
                0:       flen_val = '0;
                1:       flen_val = FlenW'(1);
                default: flen_val = FlenW'($urandom_range(12, 2));
            endcase
            f   = (flen_val == '0) ? 1 : int'(flen_val);
            amp = $urandom_range(16000, 1);
            case ($urandom_range(9))
                0:       thr_val = '0;
                1:       thr_val = '1;
                2:       thr_val = CfgDataW'({$urandom(), $urandom()});
                default: thr_val = CfgDataW'(longint'(f) * amp * amp);
            endcase
            write_reg(CFG_FRAME_LENGTH, flen_val);
            write_reg(CFG_LEVEL_LIMIT, thr_val);
            case ($urandom_range(4))
                0:       write_reg(CFG_RATE_PERMILLE, 0);
                1:       write_reg(CFG_RATE_PERMILLE, PermilleScale);
                2:       write_reg(CFG_RATE_PERMILLE, {RateW{1'b1}});
                default: write_reg(CFG_RATE_PERMILLE, $urandom_range(1023));
            endcase
            case ($urandom_range(2))
                0:       in_idle_pct = 0;
                1:       in_idle_pct = 25;
                default: in_idle_pct = 60;
            endcase
            case ($urandom_range(2))
                0:       out_stall_pct = 0;
                1:       out_stall_pct = 20;
                default: out_stall_pct = 60;
            endcase
            repeat ($urandom_range(6, 3)) begin
                if ($urandom_range(4) == 0)
                    send_noise_recording();
                else
                    send_shaped_recording(amp, f);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and the summary checker
    // ------------------------------------------------------------------
    initial begin : result_backpressure
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if ($urandom_range(99) < out_stall_pct) begin
                hold    = pick_gap(100) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string label, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Outputs sampled at the rising edge, before the block updates them.
    always @(posedge aclk) begin
        word_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t ns: unexpected summary, expected none, actual yes=%0d found=%0d",
                         $time, m_word_is_yes, m_speech_found);
                mismatches++;
            end else begin
                want = pending_summaries.pop_front();
                check_field("word_is_yes", want.word_is_yes, m_word_is_yes);
                check_field("speech_found", want.speech_found, m_speech_found);
                check_field("span_start", want.span_start, m_span_start);
                check_field("span_end", want.span_end, m_span_end);
                check_field("crossing_count", want.crossing_count, m_crossing_count);
                summaries_checked++;
                if (m_speech_found)
                    speech_summaries++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        thr_q  = ThresholdReset;
        rate_q = RateReset;
        flen_q = FrameLenReset;
        clear_tracker();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_settings();
        test_directed_cases();
        test_random_recordings();
        settle();

        $display("Sent %0d samples in %0d recordings; %0d summaries checked, %0d with speech.",
                 samples_sent, recordings_sent, summaries_checked, speech_summaries);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("Timeout with %0d summaries outstanding.", pending_summaries.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ezwd_pkg.sv
hw/rtl/ezwd_front.sv
hw/rtl/ezwd_track.sv
hw/rtl/ezwd_decide.sv
hw/rtl/energy_zcr_word_detector_top.sv
tb/sv/tb_top.sv
